// ===== sv/csf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csf_pkg
// shared types and constants of the counting semaphore with wait queue
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int THREAD_ID_BITS = 8;
  localparam int PERMIT_BITS    = 16;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PERMIT_BITS-1:0] PERMIT_MAX   = '1;
  localparam logic [15:0]            PERMIT_RESET = 16'd1;

  // register word index on the config port
  localparam logic [0:0] REG_INITIAL_PERMITS = 1'b0;
  localparam logic [0:0] REG_FAIR_MODE       = 1'b1;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_POLL    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_FULL    = 3'd3,
    ST_RETRY   = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } csf_cmd_t;

  typedef struct packed {
    logic slot_free;
  } csf_stat_t;

endpackage : csf_pkg
`default_nettype wire

// ===== sv/counting_semaphore_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_fifo
// counting semaphore with a wait queue and an optional fair holder queue
// ----------------------------------------------------------------------------
// Each request is registered in S_IDLE while the heads of the wait and holder
// queue memories are read, then decided and committed in S_EXEC; a result still
// waiting on m_tready delays the commit of the next request.
// A new request is taken while the previous result waits. The config port
// may be written only while no request is in flight.
module counting_semaphore_fifo (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // thread_id[7:0], permit_request[23:8]
  input  wire logic [1:0]  s_tuser,   // operation[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // available_permits[15:0]
  output logic [2:0]       m_tuser,   // status[2:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import csf_pkg::*;

  csf_cmd_t    cmd;
  csf_stat_t   stat;
  status_t     out_status;
  logic [15:0] initial_permits;
  logic        fair_mode;
  logic        wr_en;
  logic        init_load;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign init_load = wr_en && (paddr[2] == REG_INITIAL_PERMITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_permits <= PERMIT_RESET;
      fair_mode       <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_INITIAL_PERMITS: initial_permits <= pwdata[15:0];
        REG_FAIR_MODE:       fair_mode       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INITIAL_PERMITS: prdata = {16'd0, initial_permits};
      REG_FAIR_MODE:       prdata = {31'd0, fair_mode};
      default:             prdata = '0;
    endcase
  end

  csf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csf_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (s_tuser),
    .in_thread_id      (s_tdata[7:0]),
    .in_permit_request (s_tdata[23:8]),
    .fair_mode         (fair_mode),
    .init_load         (init_load),
    .init_permits      (pwdata[15:0]),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_status        (out_status),
    .out_permits       (m_tdata)
  );

  assign m_tuser = out_status;

endmodule : counting_semaphore_fifo
`default_nettype wire

// ===== sv/csf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csf_ctrl
// request sequencer: takes a request, then commits it once the result slot is free
// ----------------------------------------------------------------------------
module csf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire csf_pkg::csf_stat_t stat,
  output csf_pkg::csf_cmd_t      cmd
);
  import csf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_EXEC: begin
        cmd.commit = stat.slot_free;
      end
      default: ;
    endcase
  end

endmodule : csf_ctrl
`default_nettype wire

// ===== sv/csf_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csf_dp
// permit counter, wait and holder queues, request decision and result register
// ----------------------------------------------------------------------------
module csf_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire csf_pkg::csf_cmd_t     cmd,
  output csf_pkg::csf_stat_t         stat,
  input  wire logic [1:0]            in_operation,
  input  wire logic [7:0]            in_thread_id,
  input  wire logic [15:0]           in_permit_request,
  input  wire logic                  fair_mode,
  input  wire logic                  init_load,
  input  wire logic [15:0]           init_permits,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output csf_pkg::status_t           out_status,
  output logic [15:0]                out_permits
);
  import csf_pkg::*;

  localparam int WENT_BITS = THREAD_ID_BITS + PERMIT_BITS;

  // latched request
  op_t                       op;
  logic [THREAD_ID_BITS-1:0] tid;
  logic [PERMIT_BITS-1:0]    req;

  logic [PERMIT_BITS-1:0] permit_count;
  logic [PERMIT_BITS-1:0] permit_next;

  // wait queue: {tid, count}
  logic [WENT_BITS-1:0] wait_mem [QUEUE_DEPTH];
  logic [WENT_BITS-1:0] wait_rd;
  logic [PTR_BITS-1:0]  wait_head;
  logic [PTR_BITS-1:0]  wait_tail;
  logic [CNT_BITS-1:0]  wait_cnt;

  // holder queue: tid only
  logic [THREAD_ID_BITS-1:0] hold_mem [QUEUE_DEPTH];
  logic [THREAD_ID_BITS-1:0] hold_rd;
  logic [PTR_BITS-1:0]       hold_head;
  logic [PTR_BITS-1:0]       hold_tail;
  logic [CNT_BITS-1:0]       hold_cnt;

  logic                      wait_push;
  logic                      wait_pop;
  logic                      hold_push;
  logic                      hold_pop;
  status_t                   status_next;

  logic                      wait_empty;
  logic                      wait_full;
  logic                      hold_full;
  logic [THREAD_ID_BITS-1:0] head_tid;
  logic [PERMIT_BITS-1:0]    head_need;
  logic [PERMIT_BITS:0]      rel_sum;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    if (p == PTR_BITS'(QUEUE_DEPTH - 1)) return '0;
    else return p + PTR_BITS'(1);
  endfunction

  assign stat.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= op_t'(in_operation);
      tid <= in_thread_id[THREAD_ID_BITS-1:0];
      req <= in_permit_request[PERMIT_BITS-1:0];
    end
  end

  assign wait_empty = (wait_cnt == '0);
  assign wait_full  = (wait_cnt == CNT_BITS'(QUEUE_DEPTH));
  assign hold_full  = (hold_cnt == CNT_BITS'(QUEUE_DEPTH));
  assign head_tid   = wait_rd[WENT_BITS-1:PERMIT_BITS];
  assign head_need  = wait_rd[PERMIT_BITS-1:0];
  assign rel_sum    = {1'b0, permit_count} + {1'b0, req};

  always_comb begin
    wait_push   = 1'b0;
    wait_pop    = 1'b0;
    hold_push   = 1'b0;
    hold_pop    = 1'b0;
    permit_next = permit_count;
    status_next = ST_DONE;
    unique case (op)
      OP_ACQUIRE: begin
        if (wait_empty && (req <= permit_count)) begin
          if (fair_mode && hold_full) begin
            status_next = ST_FULL;
          end else begin
            hold_push   = fair_mode;
            permit_next = permit_count - req;
          end
        end else if (wait_full) begin
          status_next = ST_FULL;
        end else begin
          wait_push   = 1'b1;
          status_next = ST_QUEUED;
        end
      end
      OP_RELEASE: begin
        if (fair_mode && ((hold_cnt == '0) || (hold_rd != tid))) begin
          status_next = ST_RETRY;
        end else begin
          hold_pop    = fair_mode;
          permit_next = rel_sum[PERMIT_BITS] ? PERMIT_MAX : rel_sum[PERMIT_BITS-1:0];
        end
      end
      OP_POLL: begin
        if (wait_empty || (head_tid != tid) || (head_need > permit_count)) begin
          status_next = ST_BLOCKED;
        end else if (fair_mode && hold_full) begin
          status_next = ST_FULL;
        end else begin
          wait_pop    = 1'b1;
          hold_push   = fair_mode;
          permit_next = permit_count - head_need;
        end
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  // queue memories, head read registered every cycle
  always_ff @(posedge clk) begin
    if (cmd.commit && wait_push) wait_mem[wait_tail] <= {tid, req};
    wait_rd <= wait_mem[wait_head];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && hold_push) hold_mem[hold_tail] <= tid;
    hold_rd <= hold_mem[hold_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_head <= '0;
      wait_tail <= '0;
      wait_cnt  <= '0;
      hold_head <= '0;
      hold_tail <= '0;
      hold_cnt  <= '0;
    end else if (cmd.commit) begin
      if (wait_push) begin
        wait_tail <= ptr_inc(wait_tail);
        wait_cnt  <= wait_cnt + CNT_BITS'(1);
      end
      if (wait_pop) begin
        wait_head <= ptr_inc(wait_head);
        wait_cnt  <= wait_cnt - CNT_BITS'(1);
      end
      if (hold_push) begin
        hold_tail <= ptr_inc(hold_tail);
        hold_cnt  <= hold_cnt + CNT_BITS'(1);
      end
      if (hold_pop) begin
        hold_head <= ptr_inc(hold_head);
        hold_cnt  <= hold_cnt - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      permit_count <= PERMIT_RESET[PERMIT_BITS-1:0];
    end else if (init_load) begin
      permit_count <= init_permits[PERMIT_BITS-1:0];
    end else if (cmd.commit) begin
      permit_count <= permit_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status  <= status_next;
      out_permits <= 16'(permit_next);
    end
  end

endmodule : csf_dp
`default_nettype wire
